@@ design/ffdb_pkg.sv @@
package ffdb_pkg;

  // Field geometry.
  localparam int SIDE  = 128;
  localparam int DEPTH = SIDE * SIDE;
  localparam int CW    = $clog2(SIDE);
  localparam int AW    = $clog2(DEPTH);

  // Item and arithmetic widths.
  localparam int PIX_W   = 8;
  localparam int IN_CW   = 7;
  localparam int KIND_W  = 2;
  localparam int SUM_W   = 11;
  localparam int PROD_W  = 2 * SUM_W;

  // Division by six of a sum of at most 1530: multiply by ceil(2^13 / 6),
  // then shift right by 13. The error stays below one sixth of a unit.
  localparam int RECIP_SH = 13;
  localparam logic [SUM_W-1:0] RECIP = SUM_W'(((1 << RECIP_SH) + 5) / 6);

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DECAY = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

  // Shared adder operations.
  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CW-1:0]    coord_t;
  typedef logic [AW-1:0]    addr_t;
  typedef logic [SUM_W-1:0] sum_t;

  typedef struct packed {
    logic op;
    sum_t a;
    sum_t b;
  } alu_in_t;

  typedef struct packed {
    logic borrow;
    sum_t res;
  } alu_out_t;

  // Reduces an input coordinate modulo SIDE by restoring compare-subtract.
  function automatic coord_t reduce_coord(input logic [IN_CW-1:0] x);
    logic [IN_CW:0] t;
    t = {1'b0, x};
    for (int k = IN_CW - 1; k >= 0; k--) begin
      if (32'(t) >= (SIDE << k)) begin
        t = t - (IN_CW+1)'(SIDE << k);
      end
    end
    return coord_t'(t);
  endfunction

  function automatic addr_t cell_addr(input coord_t r, input coord_t c);
    return addr_t'(r) * addr_t'(SIDE) + addr_t'(c);
  endfunction

  function automatic coord_t coord_next(input coord_t x);
    return (x == coord_t'(SIDE - 1)) ? '0 : coord_t'(x + 1'b1);
  endfunction

  function automatic coord_t coord_prev(input coord_t x);
    return (x == '0) ? coord_t'(SIDE - 1) : coord_t'(x - 1'b1);
  endfunction

endpackage

@@ design/ffdb_ram.sv @@
module ffdb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ design/ffdb_alu.sv @@
module ffdb_alu (
  input  ffdb_pkg::alu_in_t  alu_in,
  output ffdb_pkg::alu_out_t alu_out
);
  import ffdb_pkg::*;

  logic [SUM_W:0] full;

  // One adder serves both the blur sum and the decay subtraction; the top bit
  // is the borrow of a subtraction.
  always_comb begin
    if (alu_in.op == ALU_SUB) begin
      full = {1'b0, alu_in.a} - {1'b0, alu_in.b};
    end else begin
      full = {1'b0, alu_in.a} + {1'b0, alu_in.b};
    end
    alu_out.borrow = full[SUM_W];
    alu_out.res    = full[SUM_W-1:0];
  end

endmodule

@@ design/fire_field_decay_and_blur_core.sv @@
// Channel  | Direction | Handshake                       | Payload
// in_      | input     | in_valid / in_stall             | kind, col, row, pixel_value
// out_     | output    | out_valid / out_stall           | result_value
// cfg_     | input     | APB write at psel&penable&pwrite | heat_level at address 0
//
// A request is taken when the block is idle; a write goes through ST_WR, a decay through ST_DCR
// and ST_DCW, and a blurred read through ST_RD, ST_MUL and ST_QUO, each then ST_FIN, which loads
// the result register once it is free; the next request is taken after that. Because the
// heat memory has a single port, six steps issue the five neighbor reads one per cycle and fold
// them into the sum, then ST_MUL multiplies by the reciprocal of six and ST_QUO picks the quotient.
// After reset the block sweeps the 16384-entry heat memory to zero, one entry
// per cycle, and accepts no request until the sweep ends; configuration
// writes are taken throughout. A stalled result waits in the output register;
// the next request may be accepted meanwhile and its result waits behind it.
module fire_field_decay_and_blur_core (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ffdb_pkg::KIND_W-1:0]   in_kind,
  input  logic [ffdb_pkg::IN_CW-1:0]    in_col,
  input  logic [ffdb_pkg::IN_CW-1:0]    in_row,
  input  logic [ffdb_pkg::PIX_W-1:0]    in_pixel_value,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ffdb_pkg::PIX_W-1:0]    out_result_value,

  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [1:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import ffdb_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_CLEAR = 4'd1;
  localparam logic [3:0] ST_WR    = 4'd2;
  localparam logic [3:0] ST_RD    = 4'd3;
  localparam logic [3:0] ST_MUL   = 4'd4;
  localparam logic [3:0] ST_QUO   = 4'd5;
  localparam logic [3:0] ST_DCR   = 4'd6;
  localparam logic [3:0] ST_DCW   = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  localparam logic [1:0] REG_HEAT_LEVEL = 2'd0;

  // Blur read steps: center, up, down, left, right, then the last sum.
  localparam logic [2:0] STEP_CENTER = 3'd0;
  localparam logic [2:0] STEP_UP     = 3'd1;
  localparam logic [2:0] STEP_DOWN   = 3'd2;
  localparam logic [2:0] STEP_LEFT   = 3'd3;
  localparam logic [2:0] STEP_RIGHT  = 3'd4;
  localparam logic [2:0] STEP_LAST   = 3'd5;

  logic [3:0]        state_r, state_nxt;
  logic [2:0]        step_r, step_nxt;
  addr_t             clr_r, clr_nxt;
  coord_t            row_r, row_nxt;
  coord_t            col_r, col_nxt;
  sum_t              acc_r, acc_nxt;
  logic [PROD_W-1:0] prod_r, prod_nxt;
  pix_t              res_r, res_nxt;
  pix_t              heat_level_r, heat_level_nxt;
  logic              out_valid_r, out_valid_nxt;
  pix_t              out_value_r, out_value_nxt;

  logic     mem_we;
  addr_t    mem_addr;
  pix_t     mem_wdata;
  pix_t     mem_rdata;
  addr_t    nb_addr;
  sum_t     dec;
  alu_in_t  alu_in;
  alu_out_t alu_out;
  logic     in_take;
  logic     slot_free;
  logic     cfg_write;

  ffdb_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_heat_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  ffdb_alu u_alu (
    .alu_in  (alu_in),
    .alu_out (alu_out)
  );

  assign in_stall   = (state_r != ST_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign slot_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;

  // Configuration port: always ready, one register.
  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr == REG_HEAT_LEVEL) ? {24'd0, heat_level_r} : 32'd0;

  always_comb begin
    heat_level_nxt = heat_level_r;
    if (cfg_write && (cfg_paddr == REG_HEAT_LEVEL)) begin
      heat_level_nxt = cfg_pwdata[PIX_W-1:0];
    end
  end

  // Decay amount: floor((255 - heat) / 8) + 1, i.e. the inverted level shifted.
  // The inversion is kept at pixel width so only the low eight bits flip.
  assign dec = sum_t'(pix_t'(~heat_level_r) >> 3) + 1'b1;

  // Address of the neighbor read in the current blur step.
  always_comb begin
    case (step_r)
      STEP_CENTER: nb_addr = cell_addr(row_r, col_r);
      STEP_UP:     nb_addr = cell_addr(coord_prev(row_r), col_r);
      STEP_DOWN:   nb_addr = cell_addr(coord_next(row_r), col_r);
      STEP_LEFT:   nb_addr = cell_addr(row_r, coord_prev(col_r));
      STEP_RIGHT:  nb_addr = cell_addr(row_r, coord_next(col_r));
      default:     nb_addr = cell_addr(row_r, col_r);
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    clr_nxt   = clr_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    res_nxt   = res_r;

    mem_we    = 1'b0;
    mem_addr  = cell_addr(row_r, col_r);
    mem_wdata = res_r;

    alu_in.op = ALU_ADD;
    alu_in.a  = acc_r;
    alu_in.b  = sum_t'(mem_rdata);

    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;

    case (state_r)
      ST_CLEAR: begin
        // Zero sweep of the heat memory after reset.
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = '0;
        clr_nxt   = addr_t'(clr_r + 1'b1);
        if (clr_r == addr_t'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_take) begin
          row_nxt  = reduce_coord(in_row);
          col_nxt  = reduce_coord(in_col);
          step_nxt = STEP_CENTER;
          acc_nxt  = '0;
          case (in_kind)
            KIND_WRITE: begin
              res_nxt   = in_pixel_value;
              state_nxt = ST_WR;
            end
            KIND_READ:  state_nxt = ST_RD;
            KIND_DECAY: state_nxt = ST_DCR;
            default: begin
              res_nxt   = '0;
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_WR: begin
        mem_we    = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_RD: begin
        // Issue one neighbor read per step and fold in the pixel read in the
        // step before; the center pixel counts twice.
        mem_addr = nb_addr;
        step_nxt = step_r + 1'b1;
        if (step_r != STEP_CENTER) begin
          if (step_r == STEP_UP) begin
            alu_in.b = sum_t'({mem_rdata, 1'b0});
          end
          acc_nxt = alu_out.res;
        end
        if (step_r == STEP_LAST) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = PROD_W'(acc_r) * PROD_W'(RECIP);
        state_nxt = ST_QUO;
      end
      ST_QUO: begin
        res_nxt   = prod_r[RECIP_SH +: PIX_W];
        state_nxt = ST_FIN;
      end
      ST_DCR: begin
        state_nxt = ST_DCW;
      end
      ST_DCW: begin
        // Subtract the decay amount, clamping at zero on borrow.
        alu_in.op = ALU_SUB;
        alu_in.a  = sum_t'(mem_rdata);
        alu_in.b  = dec;
        res_nxt   = alu_out.borrow ? '0 : alu_out.res[PIX_W-1:0];
        mem_we    = 1'b1;
        mem_wdata = res_nxt;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      step_r       <= STEP_CENTER;
      clr_r        <= '0;
      heat_level_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      step_r       <= step_nxt;
      clr_r        <= clr_nxt;
      heat_level_r <= heat_level_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    acc_r       <= acc_nxt;
    prod_r      <= prod_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
  end

endmodule

@@ design/ffdb_chk.sv @@
module ffdb_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [ffdb_pkg::KIND_W-1:0] in_kind,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [ffdb_pkg::PIX_W-1:0]  out_result_value
);
  import ffdb_pkg::*;

  // A held result keeps its value.
  a_out_hold_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_result_value))
    else $error("result changed while stalled");

  // A held result stays valid.
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // The block works on one request at a time.
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted while busy");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An unused kind taken while the result slot is empty yields a zero result.
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_NONE) && !out_valid
      |=> ##1 (out_valid && (out_result_value == '0)))
    else $error("unused kind result wrong");

endmodule

bind fire_field_decay_and_blur_core ffdb_chk u_ffdb_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_kind          (in_kind),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_result_value (out_result_value)
);
